// ----- rtl/gha_pkg.sv -----
// Shared widths, codes and controller/datapath interface types for the handle allocator.
package gha_pkg;

    localparam int IDX_W = 12;
    localparam int GEN_W = 8;
    localparam int CNT_W = IDX_W + 1;
    localparam int OP_W = 2;
    localparam int STAT_W = 2;

    localparam logic [CNT_W-1:0] SLOTS = CNT_W'(1) << IDX_W;
    localparam logic [CNT_W-1:0] REUSE_RESET = CNT_W'(1024);
    localparam logic [CNT_W-1:0] FRESH_RESET = CNT_W'(1);

    localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
    localparam logic [OP_W-1:0] OP_DESTROY = 2'd1;
    localparam logic [OP_W-1:0] OP_ALIVE = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_INDEX = 2'd1;
    localparam logic [STAT_W-1:0] ST_NEVER_ALLOC = 2'd2;

    typedef struct packed {
        logic capture;
        logic pop;
        logic g_rd_idx;
        logic g_rd_q;
        logic res_full;
        logic res_bad;
        logic res_fresh;
        logic res_reuse;
        logic res_destroy;
        logic res_alive;
        logic emit;
    } ctl_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            reuse;
        logic            fresh_avail;
        logic            idx_valid;
        logic            out_busy;
    } dp_stat_t;

endpackage

// ----- rtl/gha_cmd_if.sv -----
// Request channel carrying one allocator operation per beat.
interface gha_cmd_if
    import gha_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  opcode;
    logic [IDX_W-1:0] handle_index;
    logic [GEN_W-1:0] handle_generation;

    modport source (output valid, output opcode, output handle_index,
                    output handle_generation, input ready);
    modport sink (input valid, input opcode, input handle_index,
                  input handle_generation, output ready);
endinterface

// ----- rtl/gha_rsp_if.sv -----
// Response channel carrying one allocator result per beat.
interface gha_rsp_if
    import gha_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [IDX_W-1:0]   out_index;
    logic [GEN_W-1:0]   out_generation;
    logic               is_alive;
    logic [STAT_W-1:0]  status;

    modport source (output valid, output out_index, output out_generation,
                    output is_alive, output status, input ready);
    modport sink (input valid, input out_index, input out_generation,
                  input is_alive, input status, output ready);
endinterface

// ----- rtl/gha_ctrl.sv -----
// Controller state machine sequencing one allocator operation at a time.
module gha_ctrl
    import gha_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    input  dp_stat_t stat,
    output logic     cmd_ready,
    output ctl_cmd_t ctl
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_QREAD = 3'd2;
    localparam logic [2:0] S_GREAD = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl = '0;
        cmd_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.op == OP_CREATE)
                begin
                    if (stat.reuse)
                    begin
                        ctl.pop = 1'b1;
                        state_next = S_QREAD;
                    end
                    else if (stat.fresh_avail)
                    begin
                        ctl.res_fresh = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ctl.res_full = 1'b1;
                        state_next = S_DONE;
                    end
                end
                else if (!stat.idx_valid)
                begin
                    ctl.res_bad = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    ctl.g_rd_idx = 1'b1;
                    state_next = S_GREAD;
                end
            end
            S_QREAD:
            begin
                ctl.g_rd_q = 1'b1;
                state_next = S_GREAD;
            end
            S_GREAD:
            begin
                if (stat.op == OP_CREATE)
                begin
                    ctl.res_reuse = 1'b1;
                end
                else if (stat.op == OP_DESTROY)
                begin
                    ctl.res_destroy = 1'b1;
                end
                else
                begin
                    ctl.res_alive = 1'b1;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    ctl.emit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/gha_dp.sv -----
// Datapath with the generation store, free index queue, counters and result registers.
module gha_dp
    import gha_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [CNT_W-1:0]   cfg_wdata,
    input  ctl_cmd_t           ctl,
    input  logic [OP_W-1:0]    opcode,
    input  logic [IDX_W-1:0]   handle_index,
    input  logic [GEN_W-1:0]   handle_generation,
    input  logic               rsp_ready,
    output dp_stat_t           stat,
    output logic               rsp_valid,
    output logic [IDX_W-1:0]   out_index,
    output logic [GEN_W-1:0]   out_generation,
    output logic               is_alive,
    output logic [STAT_W-1:0]  status
);

    logic [GEN_W-1:0] gen_mem [SLOTS];
    logic [IDX_W-1:0] queue_mem [SLOTS];

    logic [CNT_W-1:0]  min_free_reg;
    logic [IDX_W-1:0]  head_reg;
    logic [IDX_W-1:0]  tail_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  fresh_reg;

    logic [OP_W-1:0]   op_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [GEN_W-1:0]  hgen_reg;
    logic [IDX_W-1:0]  n_reg;
    logic [IDX_W-1:0]  q_rdata_reg;
    logic [GEN_W-1:0]  g_rdata_reg;

    logic [IDX_W-1:0]  res_index_reg;
    logic [GEN_W-1:0]  res_gen_reg;
    logic              res_alive_reg;
    logic [STAT_W-1:0] res_status_reg;

    logic               out_valid_reg;
    logic [IDX_W-1:0]   out_index_reg;
    logic [GEN_W-1:0]   out_gen_reg;
    logic               out_alive_reg;
    logic [STAT_W-1:0]  out_status_reg;

    logic [GEN_W-1:0] gen_bumped;
    logic             push;
    logic             g_wr;
    logic [IDX_W-1:0] g_waddr;
    logic [GEN_W-1:0] g_wdata;
    logic [IDX_W-1:0] g_raddr;

    assign gen_bumped = g_rdata_reg + GEN_W'(1);
    assign push = ctl.res_destroy && (count_reg < SLOTS);
    assign g_wr = ctl.res_fresh || ctl.res_destroy;
    assign g_waddr = ctl.res_fresh ? fresh_reg[IDX_W-1:0] : idx_reg;
    assign g_wdata = ctl.res_fresh ? '0 : gen_bumped;
    assign g_raddr = ctl.g_rd_q ? q_rdata_reg : idx_reg;

    assign stat.op = op_reg;
    assign stat.reuse = count_reg > min_free_reg;
    assign stat.fresh_avail = fresh_reg < SLOTS;
    assign stat.idx_valid = {1'b0, idx_reg} < fresh_reg;
    assign stat.out_busy = out_valid_reg && !rsp_ready;

    always_ff @(posedge clk)
    begin
        if (g_wr)
        begin
            gen_mem[g_waddr] <= g_wdata;
        end
        if (ctl.g_rd_idx || ctl.g_rd_q)
        begin
            g_rdata_reg <= gen_mem[g_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[tail_reg] <= idx_reg;
        end
        if (ctl.pop)
        begin
            q_rdata_reg <= queue_mem[head_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_free_reg <= REUSE_RESET;
            head_reg <= '0;
            tail_reg <= '0;
            count_reg <= '0;
            fresh_reg <= FRESH_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                min_free_reg <= cfg_wdata;
            end
            if (ctl.pop)
            begin
                head_reg <= head_reg + IDX_W'(1);
                count_reg <= count_reg - CNT_W'(1);
            end
            if (push)
            begin
                tail_reg <= tail_reg + IDX_W'(1);
                count_reg <= count_reg + CNT_W'(1);
            end
            if (ctl.res_fresh)
            begin
                fresh_reg <= fresh_reg + CNT_W'(1);
            end
            if (ctl.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            op_reg <= opcode;
            idx_reg <= handle_index;
            hgen_reg <= handle_generation;
        end
        if (ctl.g_rd_q)
        begin
            n_reg <= q_rdata_reg;
        end
        if (ctl.res_full)
        begin
            res_index_reg <= '0;
            res_gen_reg <= '0;
            res_alive_reg <= 1'b0;
            res_status_reg <= ST_NO_INDEX;
        end
        if (ctl.res_bad)
        begin
            res_index_reg <= idx_reg;
            res_gen_reg <= '0;
            res_alive_reg <= 1'b0;
            res_status_reg <= ST_NEVER_ALLOC;
        end
        if (ctl.res_fresh)
        begin
            res_index_reg <= fresh_reg[IDX_W-1:0];
            res_gen_reg <= '0;
            res_alive_reg <= 1'b1;
            res_status_reg <= ST_OK;
        end
        if (ctl.res_reuse)
        begin
            res_index_reg <= n_reg;
            res_gen_reg <= g_rdata_reg;
            res_alive_reg <= 1'b1;
            res_status_reg <= ST_OK;
        end
        if (ctl.res_destroy)
        begin
            res_index_reg <= idx_reg;
            res_gen_reg <= gen_bumped;
            res_alive_reg <= 1'b0;
            res_status_reg <= ST_OK;
        end
        if (ctl.res_alive)
        begin
            res_index_reg <= idx_reg;
            res_gen_reg <= g_rdata_reg;
            res_alive_reg <= (g_rdata_reg == hgen_reg);
            res_status_reg <= ST_OK;
        end
        if (ctl.emit)
        begin
            out_index_reg <= res_index_reg;
            out_gen_reg <= res_gen_reg;
            out_alive_reg <= res_alive_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign out_generation = out_gen_reg;
    assign is_alive = out_alive_reg;
    assign status = out_status_reg;

endmodule

// ----- rtl/generational_handle_allocator_core.sv -----
// An accepted operation is decided first. Create from a fresh index, a full allocator and a
// never allocated index then go straight to the result; destroy and alive first read the
// generation store, and create that reuses a queued index reads the queue, then the store.
// One operation is in flight at a time, so a new beat is taken in the cycle after the result
// moves to the output register, which waits while an earlier response is still not taken.
// Reset clears the counters, loads the threshold with 1024 and reserves index 0.
module generational_handle_allocator_core
    import gha_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CNT_W-1:0]  cfg_wdata,
    gha_cmd_if.sink           cmd,
    gha_rsp_if.source         rsp
);

    ctl_cmd_t ctl;
    dp_stat_t stat;
    logic     ready_int;

    gha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .stat      (stat),
        .cmd_ready (ready_int),
        .ctl       (ctl)
    );

    gha_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .ctl               (ctl),
        .opcode            (cmd.opcode),
        .handle_index      (cmd.handle_index),
        .handle_generation (cmd.handle_generation),
        .rsp_ready         (rsp.ready),
        .stat              (stat),
        .rsp_valid         (rsp.valid),
        .out_index         (rsp.out_index),
        .out_generation    (rsp.out_generation),
        .is_alive          (rsp.is_alive),
        .status            (rsp.status)
    );

    assign cmd.ready = ready_int;

endmodule

// ----- bench/generational_handle_allocator_core_tb.sv -----
// Self-checking testbench for the generational handle allocator core with a built-in predictor.
module generational_handle_allocator_core_tb
    import gha_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 1 << IDX_W;
    localparam int BACKLOG_MAX = 16;
    localparam int HOLD_AT = 150;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] idx;
        logic [GEN_W-1:0] gen;
    } alloc_req_t;

    typedef struct packed {
        logic [IDX_W-1:0]  index;
        logic [GEN_W-1:0]  generation;
        logic              alive;
        logic [STAT_W-1:0] status;
    } alloc_rsp_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CNT_W-1:0] cfg_wdata;

    gha_cmd_if cmd();
    gha_rsp_if rsp();

    logic       drv_valid = 1'b0;
    alloc_req_t drv_req = '0;
    logic       rsp_rdy = 1'b0;

    assign cmd.valid = drv_valid;
    assign cmd.opcode = drv_req.op;
    assign cmd.handle_index = drv_req.idx;
    assign cmd.handle_generation = drv_req.gen;
    assign rsp.ready = rsp_rdy;

    generational_handle_allocator_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow copy of the allocator state.
    logic [GEN_W-1:0] shadow_gen [0:DEPTH-1];
    logic [IDX_W-1:0] shadow_free [0:DEPTH-1];
    logic [IDX_W-1:0] free_rd;
    logic [IDX_W-1:0] free_wr;
    logic [CNT_W-1:0] free_cnt;
    logic [CNT_W-1:0] next_fresh;
    logic [CNT_W-1:0] reuse_min;

    alloc_req_t op_backlog[$];
    alloc_rsp_t handle_rsp_due[$];

    int send_idle_pct = 22;
    int rcv_idle_pct = 63;
    int hold_left = 0;
    bit hold_fired = 1'b0;
    int cmd_beats = 0;
    int rsp_beats = 0;
    int fails = 0;
    int cycles = 0;
    int n_reused = 0;
    int n_exhausted = 0;
    int n_unallocated = 0;
    int n_dropped = 0;
    int n_wraps = 0;

    function automatic alloc_rsp_t alloc_predict(alloc_req_t r);
        alloc_rsp_t res;
        logic [IDX_W-1:0] n;
        res = '0;
        if (r.op == OP_CREATE)
        begin
            if (free_cnt > reuse_min)
            begin
                n = shadow_free[free_rd];
                free_rd = free_rd + 1'b1;
                free_cnt = free_cnt - 1'b1;
                res.index = n;
                res.generation = shadow_gen[n];
                res.alive = 1'b1;
                n_reused++;
            end
            else if (next_fresh < SLOTS)
            begin
                n = next_fresh[IDX_W-1:0];
                shadow_gen[n] = '0;
                next_fresh = next_fresh + 1'b1;
                res.index = n;
                res.alive = 1'b1;
            end
            else
            begin
                res.status = ST_NO_INDEX;
                n_exhausted++;
            end
        end
        else if ({1'b0, r.idx} >= next_fresh)
        begin
            res.index = r.idx;
            res.status = ST_NEVER_ALLOC;
            n_unallocated++;
        end
        else if (r.op == OP_DESTROY)
        begin
            shadow_gen[r.idx] = shadow_gen[r.idx] + 1'b1;
            if (shadow_gen[r.idx] == '0)
                n_wraps++;
            if (free_cnt < SLOTS)
            begin
                shadow_free[free_wr] = r.idx;
                free_wr = free_wr + 1'b1;
                free_cnt = free_cnt + 1'b1;
            end
            else
                n_dropped++;
            res.index = r.idx;
            res.generation = shadow_gen[r.idx];
        end
        else
        begin
            res.index = r.idx;
            res.generation = shadow_gen[r.idx];
            res.alive = (shadow_gen[r.idx] == r.gen);
        end
        return res;
    endfunction

    // Request driver.
    always @(posedge clk)
    begin
        if (!rst_n)
            drv_valid <= 1'b0;
        else
        begin
            if (drv_valid && cmd.ready)
            begin
                handle_rsp_due.push_back(alloc_predict(drv_req));
                cmd_beats++;
            end
            if (!drv_valid || cmd.ready)
            begin
                if (op_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    drv_req <= op_backlog.pop_front();
                    drv_valid <= 1'b1;
                end
                else
                    drv_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, started once enough requests have gone in.
    always @(posedge clk)
    begin
        if (rst_n && !hold_fired && cmd_beats >= HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_fired <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Response monitor and checker.
    always @(posedge clk)
    begin : rsp_check
        alloc_rsp_t want;
        if (!rst_n)
            rsp_rdy <= 1'b0;
        else
        begin
            if (rsp.valid && rsp_rdy)
            begin
                rsp_beats++;
                if (handle_rsp_due.size() == 0)
                begin
                    $error("Unexpected response beat: out_index %0d", rsp.out_index);
                    fails++;
                end
                else
                begin
                    want = handle_rsp_due.pop_front();
                    if (rsp.out_index !== want.index)
                    begin
                        $error("out_index: expected %0d, got %0d", want.index, rsp.out_index);
                        fails++;
                    end
                    if (rsp.out_generation !== want.generation)
                    begin
                        $error("out_generation: expected %0d, got %0d",
                               want.generation, rsp.out_generation);
                        fails++;
                    end
                    if (rsp.is_alive !== want.alive)
                    begin
                        $error("is_alive: expected %0d, got %0d", want.alive, rsp.is_alive);
                        fails++;
                    end
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                        fails++;
                    end
                end
            end
            rsp_rdy <= (hold_left == 0) && ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d responses outstanding.",
                     cycles, handle_rsp_due.size());
            $display("** generational_handle_allocator_core: FAILED **");
            $finish;
        end
    end

    task automatic add_op(input logic [OP_W-1:0] op, input int idx, input int gen);
        alloc_req_t r;
        while (op_backlog.size() >= BACKLOG_MAX)
            @(posedge clk);
        r.op = op;
        r.idx = IDX_W'(idx);
        r.gen = GEN_W'(gen);
        op_backlog.push_back(r);
    endtask

    task automatic drain();
        while (op_backlog.size() != 0 || drv_valid || handle_rsp_due.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_reuse_min(input logic [CNT_W-1:0] v);
        drain();
        cfg_wdata <= v;
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        reuse_min = v;
    endtask

    // Creates at create_pct, else destroys and queries of issued indices, noise on any index.
    task automatic fill_mixed(input int count, input int create_pct);
        int pick;
        int top;
        int idx;
        int gen;
        logic [OP_W-1:0] op;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(99);
            top = int'(next_fresh) - 1;
            idx = $urandom_range(DEPTH - 1);
            gen = $urandom_range(255);
            if (pick < create_pct || top < 1)
                op = OP_CREATE;
            else if (pick >= 92)
            begin
                op = OP_W'($urandom_range(3, 1));
                idx = $urandom_range(DEPTH - 1, 1);
            end
            else
            begin
                idx = $urandom_range(top, 1);
                if ($urandom_range(99) < 40)
                    op = OP_DESTROY;
                else if ($urandom_range(9) == 0)
                    op = OP_UNUSED;
                else
                    op = OP_ALIVE;
                if ($urandom_range(3) != 0)
                    gen = shadow_gen[idx];
            end
            add_op(op, idx, gen);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        free_rd = '0;
        free_wr = '0;
        free_cnt = '0;
        next_fresh = FRESH_RESET;
        reuse_min = REUSE_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        add_op(OP_CREATE, 0, 0);
        add_op(OP_CREATE, DEPTH - 1, 255);
        add_op(OP_CREATE, 0, 0);
        add_op(OP_ALIVE, 1, 0);
        add_op(OP_ALIVE, 1, 255);
        add_op(OP_DESTROY, 2, 0);
        add_op(OP_ALIVE, 2, 0);
        add_op(OP_DESTROY, 2, 0);
        add_op(OP_DESTROY, DEPTH - 1, 0);
        add_op(OP_ALIVE, 4, 0);
        add_op(OP_UNUSED, 3, 0);
        add_op(OP_UNUSED, 2048, 8'hAA);
        add_op(OP_CREATE, 0, 0);
        set_reuse_min('0);
        add_op(OP_CREATE, 0, 0);
        add_op(OP_CREATE, 0, 0);
        add_op(OP_CREATE, 0, 0);
        add_op(OP_DESTROY, 5, 0);
        add_op(OP_ALIVE, 5, 1);

        fill_mixed(280, 40);
        set_reuse_min(SLOTS);
        fill_mixed(280, 50);

        send_idle_pct = 63;
        rcv_idle_pct = 22;
        set_reuse_min(CNT_W'(3));
        fill_mixed(280, 40);
        set_reuse_min(REUSE_RESET);
        fill_mixed(280, 35);

        send_idle_pct = 0;
        rcv_idle_pct = 0;
        set_reuse_min(CNT_W'(1));
        fill_mixed(280, 40);
        set_reuse_min('0);
        fill_mixed(200, 45);

        drain();
        repeat (12) @(posedge clk);
        $display("Checked %0d responses for %0d requests at reuse thresholds 0 to %0d.",
                 rsp_beats, cmd_beats, SLOTS);
        $display("Reused %0d, exhausted %0d, unallocated %0d, queue drops %0d, wraps %0d.",
                 n_reused, n_exhausted, n_unallocated, n_dropped, n_wraps);
        if (fails == 0)
            $display("** generational_handle_allocator_core: PASSED **");
        else
            $display("** generational_handle_allocator_core: FAILED **");
        $finish;
    end

endmodule
